// ===== rtl/core/lzwd_pkg.sv =====
// lzwd_pkg: shared constants and the command type of the lzw code decoder
// no dependencies; imported by every module of the decoder
package lzwd_pkg;

   localparam int CODE_W    = 9;
   localparam int BYTE_W    = 8;
   localparam int COUNT_W   = 3;
   localparam int ENTRY_W   = CODE_W + BYTE_W;
   localparam int STACK_AW  = 8;
   localparam int CMD_DEPTH = 4;
   localparam int CMD_AW    = 2;

   localparam logic [CODE_W-1:0]   RESERVED_CODE = 9'd256;
   localparam logic [CODE_W-1:0]   FIRST_ENTRY   = 9'd257;
   localparam logic [STACK_AW-1:0] STACK_LIMIT   = 8'd255;
   localparam logic [COUNT_W-1:0]  PACK_FULL     = 3'd4;

   typedef struct packed {
      logic              err;
      logic              kwk;
      logic              wr_en;
      logic [CODE_W-1:0] code;
      logic [CODE_W-1:0] prev_code;
   } cmd_type;

endpackage

// ===== rtl/core/lzwd_front.sv =====
// lzwd_front: accepts codes, classifies them against the dictionary fill state
// depends on lzwd_pkg; feeds commands into lzwd_cmd_fifo
module lzwd_front #(
   parameter int DICT_BITS = 9
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  logic [lzwd_pkg::CODE_W-1:0] req_code,
   input  logic                      req_end_of_stream,
   input  logic                      fifo_full,
   output logic                      req_full,
   output logic                      cmd_push,
   output lzwd_pkg::cmd_type         cmd_data,
   output logic [DICT_BITS-1:0]      cmd_addr
);
   import lzwd_pkg::*;

   localparam int CW = DICT_BITS + 1;

   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              have_prev_ff, have_prev_in;
   logic [CODE_W-1:0] prev_code_ff, prev_code_in;
   logic              accept;
   logic [CW-1:0]     code_ext;
   logic              is_rsv, is_bad, wr_en;

   assign req_full = fifo_full;
   assign accept   = req_push && !fifo_full;
   assign code_ext = CW'(req_code);
   assign is_rsv   = (req_code == RESERVED_CODE);
   assign is_bad   = (code_ext > cnt_ff) || ((code_ext == cnt_ff) && !have_prev_ff);
   assign wr_en    = have_prev_ff && !cnt_ff[DICT_BITS];

   assign cmd_push           = accept && !is_rsv;
   assign cmd_data.err       = is_bad;
   assign cmd_data.kwk       = (code_ext == cnt_ff);
   assign cmd_data.wr_en     = wr_en;
   assign cmd_data.code      = req_code;
   assign cmd_data.prev_code = prev_code_ff;
   assign cmd_addr           = cnt_ff[DICT_BITS-1:0];

   always_comb begin
      cnt_in       = cnt_ff;
      have_prev_in = have_prev_ff;
      prev_code_in = prev_code_ff;
      if (accept) begin
         if (!is_rsv && !is_bad) begin
            if (wr_en) begin
               cnt_in = cnt_ff + CW'(1);
            end
            prev_code_in = req_code;
            have_prev_in = 1'b1;
         end
         if (req_end_of_stream) begin
            cnt_in       = CW'(FIRST_ENTRY);
            have_prev_in = 1'b0;
            prev_code_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= CW'(FIRST_ENTRY);
         have_prev_ff <= 1'b0;
         prev_code_ff <= '0;
      end else begin
         cnt_ff       <= cnt_in;
         have_prev_ff <= have_prev_in;
         prev_code_ff <= prev_code_in;
      end
   end

endmodule

// ===== rtl/core/lzwd_cmd_fifo.sv =====
// lzwd_cmd_fifo: short command queue between the front and back of the decoder
// depends on lzwd_pkg
module lzwd_cmd_fifo #(
   parameter int DICT_BITS = 9
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  lzwd_pkg::cmd_type    push_cmd,
   input  logic [DICT_BITS-1:0] push_addr,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output lzwd_pkg::cmd_type    head_cmd,
   output logic [DICT_BITS-1:0] head_addr
);
   import lzwd_pkg::*;

   cmd_type              slot_cmd_ff  [CMD_DEPTH];
   logic [DICT_BITS-1:0] slot_addr_ff [CMD_DEPTH];
   logic [CMD_AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CMD_AW:0]      count_ff, count_in;
   logic                 do_push, do_pop;

   assign full      = (count_ff == (CMD_AW+1)'(CMD_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_cmd  = slot_cmd_ff[rd_ptr_ff];
   assign head_addr = slot_addr_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_cmd_ff[wr_ptr_ff]  <= push_cmd;
         slot_addr_ff[wr_ptr_ff] <= push_addr;
      end
   end

endmodule

// ===== rtl/core/lzwd_back.sv =====
// lzwd_back: walks prefix chains, builds the dictionary and packs output bytes
// depends on lzwd_pkg; takes commands from lzwd_cmd_fifo
module lzwd_back #(
   parameter int DICT_BITS = 9
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_empty,
   input  lzwd_pkg::cmd_type                 cmd,
   input  logic [DICT_BITS-1:0]              cmd_addr,
   output logic                              cmd_pop,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [lzwd_pkg::BYTE_W-1:0]       rsp_byte0,
   output logic [lzwd_pkg::BYTE_W-1:0]       rsp_byte1,
   output logic [lzwd_pkg::BYTE_W-1:0]       rsp_byte2,
   output logic [lzwd_pkg::BYTE_W-1:0]       rsp_byte3,
   output logic [lzwd_pkg::COUNT_W-1:0]      rsp_byte_count,
   output logic                              rsp_last,
   output logic                              rsp_bad_code
);
   import lzwd_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;
   localparam int ENTRY_DEPTH = 1 << DICT_BITS;
   localparam int STACK_DEPTH = 1 << STACK_AW;

   logic [ENTRY_W-1:0] ent_mem [ENTRY_DEPTH];
   logic [BYTE_W-1:0]  stk_mem [STACK_DEPTH];

   logic [1:0]                    state_ff, state_in;
   logic [ENTRY_W-1:0]            ent_rd_ff;
   logic [BYTE_W-1:0]             stk_rd_ff;
   logic [STACK_AW-1:0]           stack_top_ff, stack_top_in;
   logic                          rd_pend_ff, rd_pend_in;
   logic [3:0][BYTE_W-1:0]        pack_ff, pack_in, pack_mid;
   logic [COUNT_W-1:0]            pack_cnt_ff, pack_cnt_in, cnt_mid, cnt_after;
   logic [BYTE_W-1:0]             prev_first_ff, prev_first_in;
   logic                          out_vld_ff, out_vld_in;
   logic [3:0][BYTE_W-1:0]        out_byte_ff, out_byte_in;
   logic [COUNT_W-1:0]            out_count_ff, out_count_in;
   logic                          out_last_ff, out_last_in;
   logic                          out_bad_ff, out_bad_in;

   logic                          out_free, finish, do_flush, flush_last;
   logic [BYTE_W-1:0]             first_byte;
   logic [CODE_W-1:0]             start_cur, walk_nxt;
   logic                          ent_rd_en, ent_we;
   logic [CODE_W-1:0]             ent_rd_code;
   logic                          stk_we, stk_re;
   logic [STACK_AW-1:0]           stk_waddr, stk_raddr;
   logic [BYTE_W-1:0]             stk_wdata;

   assign out_free  = !out_vld_ff || rsp_pop;
   assign start_cur = cmd.kwk ? cmd.prev_code : cmd.code;
   assign walk_nxt  = ent_rd_ff[ENTRY_W-1:BYTE_W];

   assign rsp_empty      = !out_vld_ff;
   assign rsp_byte0      = out_byte_ff[0];
   assign rsp_byte1      = out_byte_ff[1];
   assign rsp_byte2      = out_byte_ff[2];
   assign rsp_byte3      = out_byte_ff[3];
   assign rsp_byte_count = out_count_ff;
   assign rsp_last       = out_last_ff;
   assign rsp_bad_code   = out_bad_ff;

   // absorb the stack byte read last cycle
   always_comb begin
      pack_mid = pack_ff;
      cnt_mid  = pack_cnt_ff;
      if (rd_pend_ff) begin
         pack_mid[pack_cnt_ff[1:0]] = stk_rd_ff;
         cnt_mid = pack_cnt_ff + 3'd1;
      end
   end

   assign flush_last = (stack_top_ff == '0);
   assign do_flush   = (state_ff == ST_EMIT) && out_free && (cnt_mid != '0) &&
                       ((cnt_mid == PACK_FULL) || flush_last);
   assign cnt_after  = do_flush ? '0 : cnt_mid;

   always_comb begin
      state_in      = state_ff;
      cmd_pop       = 1'b0;
      finish        = 1'b0;
      first_byte    = '0;
      ent_rd_en     = 1'b0;
      ent_rd_code   = '0;
      ent_we        = 1'b0;
      stk_we        = 1'b0;
      stk_waddr     = stack_top_ff;
      stk_wdata     = '0;
      stk_re        = 1'b0;
      stk_raddr     = stack_top_ff - 1'b1;
      stack_top_in  = stack_top_ff;
      rd_pend_in    = 1'b0;
      pack_in       = pack_ff;
      pack_cnt_in   = pack_cnt_ff;
      prev_first_in = prev_first_ff;
      out_vld_in    = out_vld_ff && !rsp_pop;
      out_byte_in   = out_byte_ff;
      out_count_in  = out_count_ff;
      out_last_in   = out_last_ff;
      out_bad_in    = out_bad_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               if (cmd.err) begin
                  if (out_free) begin
                     out_vld_in   = 1'b1;
                     out_byte_in  = '0;
                     out_count_in = '0;
                     out_last_in  = 1'b1;
                     out_bad_in   = 1'b1;
                     cmd_pop      = 1'b1;
                  end
               end else begin
                  stack_top_in = '0;
                  if (cmd.kwk) begin
                     stk_we       = 1'b1;
                     stk_waddr    = '0;
                     stk_wdata    = prev_first_ff;
                     stack_top_in = STACK_AW'(1);
                  end
                  if (start_cur >= FIRST_ENTRY) begin
                     ent_rd_en   = 1'b1;
                     ent_rd_code = start_cur;
                     state_in    = ST_WALK;
                  end else begin
                     finish     = 1'b1;
                     first_byte = start_cur[BYTE_W-1:0];
                  end
               end
            end
         end
         ST_WALK: begin
            if (stack_top_ff != STACK_LIMIT) begin
               stk_we       = 1'b1;
               stk_wdata    = ent_rd_ff[BYTE_W-1:0];
               stack_top_in = stack_top_ff + 1'b1;
            end
            if (walk_nxt >= FIRST_ENTRY) begin
               ent_rd_en   = 1'b1;
               ent_rd_code = walk_nxt;
            end else begin
               finish     = 1'b1;
               first_byte = walk_nxt[BYTE_W-1:0];
            end
         end
         ST_EMIT: begin
            if (do_flush) begin
               out_vld_in   = 1'b1;
               out_byte_in  = pack_mid;
               out_count_in = cnt_mid;
               out_last_in  = flush_last;
               out_bad_in   = 1'b0;
               pack_in      = '0;
               pack_cnt_in  = '0;
               if (flush_last) begin
                  state_in = ST_IDLE;
               end
            end else begin
               pack_in     = pack_mid;
               pack_cnt_in = cnt_mid;
            end
            if (!flush_last && (cnt_after < PACK_FULL)) begin
               stk_re       = 1'b1;
               stack_top_in = stack_top_ff - 1'b1;
               rd_pend_in   = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         cmd_pop       = 1'b1;
         ent_we        = cmd.wr_en;
         prev_first_in = first_byte;
         pack_in       = {8'h00, 8'h00, 8'h00, first_byte};
         pack_cnt_in   = 3'd1;
         state_in      = ST_EMIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         out_vld_ff   <= 1'b0;
         stack_top_ff <= '0;
         pack_cnt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         out_vld_ff   <= out_vld_in;
         stack_top_ff <= stack_top_in;
         pack_cnt_ff  <= pack_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      pack_ff       <= pack_in;
      prev_first_ff <= prev_first_in;
      out_byte_ff   <= out_byte_in;
      out_count_ff  <= out_count_in;
      out_last_ff   <= out_last_in;
      out_bad_ff    <= out_bad_in;
   end

   // dictionary entries: prefix code and appended byte
   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[cmd_addr] <= {cmd.prev_code, first_byte};
      end
      if (ent_rd_en) begin
         ent_rd_ff <= ent_mem[DICT_BITS'(ent_rd_code)];
      end
   end

   // reversed string bytes, last first
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      if (stk_re) begin
         stk_rd_ff <= stk_mem[stk_raddr];
      end
   end

endmodule

// ===== rtl/core/lzw_code_decoder_core.sv =====
// lzw_code_decoder_core: top level of the lzw code decoder
// depends on lzwd_pkg, lzwd_front, lzwd_cmd_fifo and lzwd_back
//
//   channel | direction | handshake           | payload
//   req     | in        | req_push / req_full | req_code, req_end_of_stream
//   rsp     | out       | rsp_pop / rsp_empty | rsp_byte0..3, rsp_byte_count,
//           |           |                     | rsp_last, rsp_bad_code
//
// a code reaches the back end through the command fifo registers; the back end then
// starts, walks the prefix chain one dictionary entry at a time (entry memory read
// port) and then pops the decoded bytes off the stack (stack memory read port)
// an error code yields one empty item and a reserved code none; up to four codes wait between the parts
// synchronous active-high reset; no clearing pass, memories need none
// a stalled result holds the back end while the front keeps taking codes until the fifo is full
module lzw_code_decoder_core #(
   parameter int DICT_BITS = 9
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [lzwd_pkg::CODE_W-1:0]  req_code,
   input  logic                         req_end_of_stream,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [lzwd_pkg::BYTE_W-1:0]  rsp_byte0,
   output logic [lzwd_pkg::BYTE_W-1:0]  rsp_byte1,
   output logic [lzwd_pkg::BYTE_W-1:0]  rsp_byte2,
   output logic [lzwd_pkg::BYTE_W-1:0]  rsp_byte3,
   output logic [lzwd_pkg::COUNT_W-1:0] rsp_byte_count,
   output logic                         rsp_last,
   output logic                         rsp_bad_code
);
   import lzwd_pkg::*;

   logic                 fifo_full, fifo_empty, fifo_push, fifo_pop;
   cmd_type              push_cmd, head_cmd;
   logic [DICT_BITS-1:0] push_addr, head_addr;

   lzwd_front #(.DICT_BITS(DICT_BITS)) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_code          (req_code),
      .req_end_of_stream (req_end_of_stream),
      .fifo_full         (fifo_full),
      .req_full          (req_full),
      .cmd_push          (fifo_push),
      .cmd_data          (push_cmd),
      .cmd_addr          (push_addr)
   );

   lzwd_cmd_fifo #(.DICT_BITS(DICT_BITS)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_cmd  (push_cmd),
      .push_addr (push_addr),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .empty     (fifo_empty),
      .head_cmd  (head_cmd),
      .head_addr (head_addr)
   );

   lzwd_back #(.DICT_BITS(DICT_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_empty      (fifo_empty),
      .cmd            (head_cmd),
      .cmd_addr       (head_addr),
      .cmd_pop        (fifo_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_byte0      (rsp_byte0),
      .rsp_byte1      (rsp_byte1),
      .rsp_byte2      (rsp_byte2),
      .rsp_byte3      (rsp_byte3),
      .rsp_byte_count (rsp_byte_count),
      .rsp_last       (rsp_last),
      .rsp_bad_code   (rsp_bad_code)
   );

endmodule

// ===== rtl/core/lzwd_checker.sv =====
// lzwd_checker: port-level checks on the decoder result channel
// depends on lzwd_pkg; bound to lzw_code_decoder_core
module lzwd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_empty,
   input logic                         rsp_pop,
   input logic [lzwd_pkg::BYTE_W-1:0]  rsp_byte0,
   input logic [lzwd_pkg::BYTE_W-1:0]  rsp_byte1,
   input logic [lzwd_pkg::BYTE_W-1:0]  rsp_byte2,
   input logic [lzwd_pkg::BYTE_W-1:0]  rsp_byte3,
   input logic [lzwd_pkg::COUNT_W-1:0] rsp_byte_count,
   input logic                         rsp_last,
   input logic                         rsp_bad_code
);
   import lzwd_pkg::*;

   // error items are empty and close their code
   a_bad_shape: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_bad_code) |-> (rsp_byte_count == '0) && rsp_last)
      else $error("bad code item malformed");

   // data items carry one to four bytes
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_bad_code) |-> (rsp_byte_count != '0) &&
                                        (rsp_byte_count <= PACK_FULL))
      else $error("byte count out of range");

   // bytes past the count are zero
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((rsp_byte_count > 3'd3) || (rsp_byte3 == '0)) &&
                     ((rsp_byte_count > 3'd2) || (rsp_byte2 == '0)) &&
                     ((rsp_byte_count > 3'd1) || (rsp_byte1 == '0)) &&
                     ((rsp_byte_count > 3'd0) || (rsp_byte0 == '0)))
      else $error("unused byte not zero");

   // a waiting item holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty && $stable(rsp_byte0) &&
         $stable(rsp_byte1) && $stable(rsp_byte2) && $stable(rsp_byte3) &&
         $stable(rsp_byte_count) && $stable(rsp_last) && $stable(rsp_bad_code))
      else $error("waiting item changed");

endmodule

bind lzw_code_decoder_core lzwd_checker u_chk (
   .clock          (clock),
   .reset          (reset),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_byte0      (rsp_byte0),
   .rsp_byte1      (rsp_byte1),
   .rsp_byte2      (rsp_byte2),
   .rsp_byte3      (rsp_byte3),
   .rsp_byte_count (rsp_byte_count),
   .rsp_last       (rsp_last),
   .rsp_bad_code   (rsp_bad_code)
);
